### design/pltsp_pkg.sv
// ----------------------------------------------------------------------------
// pltsp_pkg
// Shared constants and types of the posting list text skip parser.
// ----------------------------------------------------------------------------
package pltsp_pkg;

  // decimal accumulator width
  localparam int NUM_BITS = 31;
  // widths of the payload fields
  localparam int OUT_W    = 31;
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 2;
  // compare width for doc number against target
  localparam int CMP_W    = (NUM_BITS > OUT_W) ? NUM_BITS : OUT_W;
  // accumulate product width: acc * 10 + 9
  localparam int PROD_W   = NUM_BITS + 4;

  localparam logic [NUM_BITS-1:0] ACC_LIM = '1;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  localparam logic [KIND_W-1:0] KIND_POSTING = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_DASH,
    CLS_UNDER,
    CLS_BAD
  } chr_cls_e;

  // classified character as handed from front to back
  typedef struct packed {
    chr_cls_e         cls;
    logic [3:0]       digit;
    logic [OUT_W-1:0] target;
    logic             fin;
  } fq_entry_t;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OUT_W-1:0]  doc;
    logic [OUT_W-1:0]  tc;
    logic [OUT_W-1:0]  lst;
    logic              last;
  } res_t;

endpackage

### design/pltsp_if.sv
// ----------------------------------------------------------------------------
// pltsp_if
// Valid/ready channels for characters in and result items out.
// ----------------------------------------------------------------------------
interface pltsp_in_if;
  import pltsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic [OUT_W-1:0]  target_doc;
  logic              is_final;

  modport source (output valid, output char_byte, output target_doc, output is_final,
                  input ready);
  modport sink   (input valid, input char_byte, input target_doc, input is_final,
                  output ready);
endinterface

interface pltsp_out_if;
  import pltsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] item_kind;
  logic [OUT_W-1:0]  doc_id;
  logic [OUT_W-1:0]  term_count;
  logic [OUT_W-1:0]  list_size;
  logic              last_of_run;

  modport source (output valid, output item_kind, output doc_id, output term_count,
                  output list_size, output last_of_run, input ready);
  modport sink   (input valid, input item_kind, input doc_id, input term_count,
                  input list_size, input last_of_run, output ready);
endinterface

### design/pltsp_front.sv
// ----------------------------------------------------------------------------
// pltsp_front
// Takes characters, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module pltsp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pltsp_in_if.sink            in_i,
  output logic                fq_valid_o,
  output pltsp_pkg::fq_entry_t fq_entry_o,
  input  logic                fq_pop_i
);
  import pltsp_pkg::*;

  fq_entry_t  slot_q [2];
  fq_entry_t  slot_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx;
  logic       push;
  fq_entry_t  ent;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  // classify the character
  always_comb begin
    ent.digit  = in_i.char_byte[3:0];
    ent.target = in_i.target_doc;
    ent.fin    = in_i.is_final;
    if (in_i.char_byte >= CH_ZERO && in_i.char_byte <= CH_NINE) begin
      ent.cls = CLS_DIGIT;
    end else if (in_i.char_byte == CH_DASH) begin
      ent.cls = CLS_DASH;
    end else if (in_i.char_byte == CH_UNDER) begin
      ent.cls = CLS_UNDER;
    end else begin
      ent.cls = CLS_BAD;
    end
  end

  // two-entry shift queue, head in slot 0
  always_comb begin
    slot_d = slot_q;
    idx    = cnt_q - {1'b0, fq_pop_i};
    cnt_d  = idx + {1'b0, push};
    if (fq_pop_i) begin
      slot_d[0] = slot_q[1];
    end
    if (push) begin
      slot_d[idx[0]] = ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign fq_valid_o = (cnt_q != 2'd0);
  assign fq_entry_o = slot_q[0];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 2'd2))
    else $error("front queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_pop_i |-> fq_valid_o))
    else $error("front queue popped while empty");

endmodule

### design/pltsp_back.sv
// ----------------------------------------------------------------------------
// pltsp_back
// Parser state machine and two-entry result queue.
// ----------------------------------------------------------------------------
module pltsp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fq_valid_i,
  input  pltsp_pkg::fq_entry_t fq_entry_i,
  output logic                 fq_pop_o,
  pltsp_out_if.source          out_o
);
  import pltsp_pkg::*;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_DOC  = 3'd1;
  localparam logic [2:0] PH_FREQ = 3'd2;
  localparam logic [2:0] PH_POS  = 3'd3;

  logic [2:0]          phase_q, phase_d;
  logic [NUM_BITS-1:0] acc_q, acc_d;
  logic [NUM_BITS-1:0] held_q, held_d;
  logic [NUM_BITS-1:0] pos_q, pos_d;
  logic [NUM_BITS-1:0] list_q, list_d;
  logic                err_q, err_d;

  res_t       oslot_q [2];
  res_t       oslot_d [2];
  logic [1:0] ocnt_q, ocnt_d;
  logic [1:0] cnt_ap;
  logic       opop;
  logic       consume;

  logic [PROD_W-1:0]   prod;
  logic                bad;
  logic                a_hit, a_post, b_hit;
  logic [NUM_BITS-1:0] a_doc, a_tc;
  logic [1:0]          n_res;
  logic [OUT_W-1:0]    lst;
  res_t                r0, r1, res_a, res_b, res_c;
  fq_entry_t           e;

  assign e = fq_entry_i;

  // one parser step on the head entry
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    held_d  = held_q;
    pos_d   = pos_q;
    list_d  = list_q;
    err_d   = err_q;
    bad     = 1'b0;
    a_post  = 1'b0;
    a_doc   = held_q;
    a_tc    = acc_q;
    b_hit   = 1'b0;
    prod    = (PROD_W'(acc_q) << 3) + (PROD_W'(acc_q) << 1) + PROD_W'(e.digit);
    if (!err_q) begin
      case (e.cls)
        CLS_DIGIT: begin
          if (prod > PROD_W'(ACC_LIM)) begin
            bad = 1'b1;
          end else begin
            acc_d = prod[NUM_BITS-1:0];
          end
        end
        CLS_DASH: begin
          case (phase_q)
            PH_HDR: begin
              list_d  = acc_q;
              phase_d = PH_DOC;
            end
            PH_DOC: bad = 1'b1;
            PH_FREQ: begin
              a_post  = (CMP_W'(held_q) >= CMP_W'(e.target));
              phase_d = PH_DOC;
            end
            default: phase_d = PH_DOC;
          endcase
          acc_d = '0;
        end
        CLS_UNDER: begin
          case (phase_q)
            PH_HDR: bad = 1'b1;
            PH_DOC: begin
              held_d  = acc_q;
              phase_d = PH_FREQ;
            end
            PH_FREQ: begin
              a_post  = (CMP_W'(held_q) >= CMP_W'(e.target));
              pos_d   = acc_q;
              phase_d = PH_POS;
            end
            default: begin
              if (pos_q != '0) begin
                pos_d = pos_q - NUM_BITS'(1);
              end
            end
          endcase
          acc_d = '0;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        err_d = 1'b1;
      end
    end
    a_hit = a_post || bad;

    // final character: close an open header or frequency
    if (e.fin && !err_d) begin
      if (phase_d == PH_HDR) begin
        list_d = acc_d;
      end else if (phase_d == PH_FREQ) begin
        b_hit = (CMP_W'(held_d) >= CMP_W'(e.target));
      end
    end
    lst = OUT_W'(list_d);

    res_a.kind = bad ? KIND_ERROR : KIND_POSTING;
    res_a.doc  = bad ? '0 : OUT_W'(a_doc);
    res_a.tc   = bad ? '0 : OUT_W'(a_tc);
    res_a.lst  = lst;
    res_a.last = !e.fin;

    res_b.kind = KIND_POSTING;
    res_b.doc  = OUT_W'(held_d);
    res_b.tc   = OUT_W'(acc_d);
    res_b.lst  = lst;
    res_b.last = 1'b0;

    res_c.kind = KIND_END;
    res_c.doc  = '0;
    res_c.tc   = '0;
    res_c.lst  = lst;
    res_c.last = 1'b1;

    // a and b never both fire
    r0    = a_hit ? res_a : (b_hit ? res_b : res_c);
    r1    = res_c;
    n_res = 2'({1'b0, a_hit || b_hit} + {1'b0, e.fin});

    // end of list returns the parser to its reset state
    if (e.fin) begin
      phase_d = PH_HDR;
      acc_d   = '0;
      held_d  = '0;
      pos_d   = '0;
      list_d  = '0;
      err_d   = 1'b0;
    end
  end

  // result queue, head in slot 0
  assign opop     = out_o.valid && out_o.ready;
  assign cnt_ap   = ocnt_q - {1'b0, opop};
  assign consume  = fq_valid_i && (({1'b0, cnt_ap} + {1'b0, n_res}) <= 3'd2);
  assign fq_pop_o = consume;

  always_comb begin
    oslot_d = oslot_q;
    ocnt_d  = cnt_ap;
    if (opop) begin
      oslot_d[0] = oslot_q[1];
    end
    if (consume) begin
      ocnt_d = cnt_ap + n_res;
      if (n_res != 2'd0) begin
        oslot_d[cnt_ap[0]] = r0;
      end
      if (n_res == 2'd2) begin
        oslot_d[1] = r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      acc_q   <= '0;
      held_q  <= '0;
      pos_q   <= '0;
      list_q  <= '0;
      err_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
      if (consume) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        held_q  <= held_d;
        pos_q   <= pos_d;
        list_q  <= list_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    oslot_q <= oslot_d;
  end

  assign out_o.valid       = (ocnt_q != 2'd0);
  assign out_o.item_kind   = oslot_q[0].kind;
  assign out_o.doc_id      = oslot_q[0].doc;
  assign out_o.term_count  = oslot_q[0].tc;
  assign out_o.list_size   = oslot_q[0].lst;
  assign out_o.last_of_run = oslot_q[0].last;

  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q <= 2'd2))
    else $error("result queue overfilled");
  a_fin_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && e.fin) |=> (phase_q == PH_HDR && !err_q && acc_q == '0))
    else $error("parser not back in header phase after final character");
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.item_kind == KIND_END) |-> out_o.last_of_run)
    else $error("end item without last_of_run");
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && consume && !e.fin) |=> err_q)
    else $error("error flag dropped before final character");

endmodule

### design/posting_list_text_skip_parser_top.sv
// ----------------------------------------------------------------------------
// posting_list_text_skip_parser_top
// Streaming parser for text posting lists with skip-to-target filtering.
// ----------------------------------------------------------------------------
// A character's results pass through the front queue register, then the
//   result queue register.
// Throughput: one character per cycle while both queues have room; results
//   drain one per cycle while ready, and two-result characters hold up the parser.
// Reset: rst_ni clears both queues, the parser phase and all counters at once.
// ----------------------------------------------------------------------------
module posting_list_text_skip_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pltsp_in_if.sink   in_i,
  pltsp_out_if.source out_o
);
  import pltsp_pkg::*;

  // Front: classify each character (digit, dash, underscore, other) and
  // queue it with its target and final flag. Accepts whenever the queue has
  // a free slot, independent of the output side.
  logic      fq_valid;
  logic      fq_pop;
  fq_entry_t fq_entry;

  pltsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .fq_valid_o (fq_valid),
    .fq_entry_o (fq_entry),
    .fq_pop_i   (fq_pop)
  );

  // Back: one parser step per queued character. The step runs only when
  // the result queue has room for all of its results (up to two), so a
  // character is never half-processed.
  pltsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_valid_i (fq_valid),
    .fq_entry_i (fq_entry),
    .fq_pop_o   (fq_pop),
    .out_o      (out_o)
  );

endmodule
